/* rtl/srv_pkg.sv */
// Package: constants, types, tables and arithmetic helpers of the stereo reverb.
`timescale 1ns / 1ps
package srv_pkg;

    // Sizes
    localparam int COMB_DEPTH  = 32768;
    localparam int AP_DEPTH    = 4096;
    localparam int SAMPLE_BITS = 24;
    localparam int N_CH        = 2;
    localparam int N_COMB      = 4;
    localparam int N_AP        = 3;
    localparam int N_TAPS      = N_COMB + N_AP;
    localparam int COMB_AW     = $clog2(COMB_DEPTH);
    localparam int AP_AW       = $clog2(AP_DEPTH);
    localparam int COMB_LANES  = N_CH * N_COMB;
    localparam int AP_LANES    = N_CH * N_AP;
    localparam int LANE_W      = $clog2(COMB_LANES);
    localparam int TAP_IW      = $clog2(N_TAPS);
    localparam int K_W         = $clog2(N_COMB);

    // Configuration port
    localparam int CFG_W = 17;
    localparam int IDX_W = 2;
    typedef logic [IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_ROOM_SIZE = IDX_W'(0);
    localparam t_cfg_idx REG_DRY_WET   = IDX_W'(1);
    localparam int Q16_ONE = 65536;

    // Arithmetic widths
    localparam int GAIN_W = 16;
    localparam int PROD_W = SAMPLE_BITS + GAIN_W;
    localparam int SUM_W  = SAMPLE_BITS + 2;
    localparam int DW_W   = CFG_W + 1;
    localparam int MIX_W  = SAMPLE_BITS + DW_W;
    localparam int WIDE   = 48;

    // Tap delay math: d = floor(floor(base * room / 2^16) / 1000)
    localparam int BASE_W  = 25;
    localparam int TPROD_W = BASE_W + CFG_W;
    localparam int Q_W     = TPROD_W - 16;
    localparam int RECIP_W = 27;
    localparam int RECIP_SH = 36;
    localparam logic [RECIP_W-1:0] RECIP_1000 = RECIP_W'(68719477);
    localparam int M_W     = Q_W + RECIP_W;
    localparam int D_W     = M_W - RECIP_SH;

    localparam logic signed [GAIN_W-1:0] AP_GAIN = GAIN_W'(22938);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef struct packed {
        t_sample left;
        t_sample right;
        logic    last;
    } t_item;

    typedef struct packed {
        logic                           valid;
        logic [N_COMB-1:0][COMB_AW-1:0] comb_d;
        logic [N_AP-1:0][AP_AW-1:0]     ap_d;
    } t_taps;

    typedef enum logic [1:0] {
        TS_IDLE,
        TS_MUL,
        TS_DIV,
        TS_STORE
    } t_tap_state;

    typedef enum logic [3:0] {
        CS_CLEAR,
        CS_IDLE,
        CS_CRD,
        CS_CMUL,
        CS_CWR,
        CS_CSUM,
        CS_ARD,
        CS_AY,
        CS_AMUL,
        CS_AWR,
        CS_MXM,
        CS_MXA,
        CS_DONE
    } t_core_state;

    localparam logic signed [WIDE-1:0] SMAX = WIDE'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [WIDE-1:0] SMIN = -SMAX - WIDE'(1);

    // Base lengths in thousandths of a sample: combs first, then allpasses
    function automatic logic [BASE_W-1:0] base_milli(input logic [TAP_IW-1:0] i);
        logic [BASE_W-1:0] b;
        unique case (i)
            3'd0:    b = BASE_W'(16930872);
            3'd1:    b = BASE_W'(17636472);
            3'd2:    b = BASE_W'(19047672);
            3'd3:    b = BASE_W'(20465928);
            3'd4:    b = BASE_W'(3707928);
            3'd5:    b = BASE_W'(1188936);
            3'd6:    b = BASE_W'(398664);
            default: b = '0;
        endcase
        return b;
    endfunction

    function automatic logic signed [GAIN_W-1:0] comb_gain(input logic [K_W-1:0] k);
        logic signed [GAIN_W-1:0] g;
        unique case (k)
            2'd0: g = GAIN_W'(24315);
            2'd1: g = GAIN_W'(24019);
            2'd2: g = GAIN_W'(23429);
            2'd3: g = GAIN_W'(22839);
        endcase
        return g;
    endfunction

    // Q1.15 product rounding: add half, arithmetic shift
    function automatic logic signed [SAMPLE_BITS:0] rnd_q15(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W:0] s;
        s = (PROD_W+1)'(p) + (PROD_W+1)'(16384);
        s = s >>> 15;
        return s[SAMPLE_BITS:0];
    endfunction

    function automatic t_sample sat_s(input logic signed [WIDE-1:0] v);
        t_sample r;
        if (v > SMAX) begin
            r = SMAX[SAMPLE_BITS-1:0];
        end else if (v < SMIN) begin
            r = SMIN[SAMPLE_BITS-1:0];
        end else begin
            r = v[SAMPLE_BITS-1:0];
        end
        return r;
    endfunction

endpackage

/* rtl/srv_if.sv */
// Interfaces: sample input channel, result channel and configuration write channel.
`timescale 1ns / 1ps
interface srv_in_if;
    logic                       valid;
    logic                       ready;
    logic [srv_pkg::SAMPLE_BITS-1:0] left_in;
    logic [srv_pkg::SAMPLE_BITS-1:0] right_in;
    logic                       last_sample;
    modport source (output valid, left_in, right_in, last_sample, input ready);
    modport sink   (input valid, left_in, right_in, last_sample, output ready);
endinterface

interface srv_out_if;
    logic                       valid;
    logic                       ready;
    logic [srv_pkg::SAMPLE_BITS-1:0] left_out;
    logic [srv_pkg::SAMPLE_BITS-1:0] right_out;
    logic                       last_out;
    modport source (output valid, left_out, right_out, last_out, input ready);
    modport sink   (input valid, left_out, right_out, last_out, output ready);
endinterface

interface srv_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [srv_pkg::IDX_W-1:0]  index;
    logic [srv_pkg::CFG_W-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/stereo_schroeder_reverb_top.sv */
// Top level of the stereo Schroeder reverb: configuration registers and block wiring.
`timescale 1ns / 1ps
// Usage:
//   i_in_ch  : one stereo Q1.23 sample pair plus a last mark per transaction.
//   o_out_ch : one mixed stereo pair per input transaction, in order.
//   i_cfg    : register writes, index 0 room_size, index 1 dry_wet (unsigned Q1.16, used up to 1.0).
//              Write only while the block is idle; always ready.
// Processing: the filter engine takes one sample pair at a time and walks
//   the 8 comb taps and 6 allpass taps through the delay memories one
//   access at a time, then the two mix steps.
// Input is taken into a two-entry queue, so up to two pairs are accepted
//   ahead of the engine; a held result stalls the engine, not the queue.
// Reset: a clearing pass zeroes the delay memories; pairs are queued
//   meanwhile but processed only after it. A room_size write starts a
//   recomputation of the tap delays, during which queued pairs also wait.
// When o_out_ch.ready is low a valid result holds and the engine waits.
module stereo_schroeder_reverb_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    srv_in_if.sink     i_in_ch,
    srv_out_if.source  o_out_ch,
    srv_cfg_if.sink    i_cfg
);
    import srv_pkg::*;

    logic [CFG_W-1:0] r_room_size;
    logic [CFG_W-1:0] r_dry_wet;
    logic             cfg_wr, room_wr, fifo_full, fifo_valid, pop;
    t_item            in_item, q_item;
    t_taps            taps;

    // Configuration registers
    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid;
    assign room_wr     = cfg_wr && (i_cfg.index == REG_ROOM_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_room_size <= '0;
            r_dry_wet   <= '0;
        end else if (cfg_wr) begin
            unique case (i_cfg.index)
                REG_ROOM_SIZE: r_room_size <= i_cfg.data;
                REG_DRY_WET:   r_dry_wet   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Front: accept into the queue
    assign i_in_ch.ready = !fifo_full;
    assign in_item.left  = i_in_ch.left_in;
    assign in_item.right = i_in_ch.right_in;
    assign in_item.last  = i_in_ch.last_sample;

    srv_taps u_taps (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (room_wr),
        .i_room_size (r_room_size),
        .o_taps      (taps)
    );

    srv_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_ch.valid && !fifo_full),
        .i_item  (in_item),
        .o_full  (fifo_full),
        .i_pop   (pop),
        .o_valid (fifo_valid),
        .o_item  (q_item)
    );

    srv_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_taps       (taps),
        .i_dry_wet    (r_dry_wet),
        .i_fifo_valid (fifo_valid),
        .i_item       (q_item),
        .o_pop        (pop),
        .o_out_ch     (o_out_ch)
    );

endmodule

/* rtl/srv_taps.sv */
// Tap delay unit: turns room size into the seven tap delays, one tap at a time.
`timescale 1ns / 1ps
module srv_taps (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [srv_pkg::CFG_W-1:0] i_room_size,
    output srv_pkg::t_taps            o_taps
);
    import srv_pkg::*;

    t_tap_state             r_state, n_state;
    logic [TAP_IW-1:0]      r_idx;
    logic [TPROD_W-1:0]     r_p;
    logic [M_W-1:0]         r_m;
    t_taps                  r_taps;
    logic [D_W-1:0]         d_raw;
    logic                   last_tap;

    assign d_raw    = r_m[M_W-1:RECIP_SH];
    assign last_tap = (r_idx == TAP_IW'(N_TAPS - 1));

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= TS_MUL;
        end else if (i_start) begin
            r_state <= TS_MUL;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            TS_IDLE:  n_state = TS_IDLE;
            TS_MUL:   n_state = TS_DIV;
            TS_DIV:   n_state = TS_STORE;
            TS_STORE: n_state = last_tap ? TS_IDLE : TS_MUL;
            default:  n_state = TS_IDLE;
        endcase
    end

    // Datapath: multiply, reciprocal multiply, clamp and store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx        <= '0;
            r_taps.valid <= 1'b0;
        end else if (i_start) begin
            r_idx        <= '0;
            r_taps.valid <= 1'b0;
        end else begin
            unique case (r_state)
                TS_MUL: r_p <= TPROD_W'(base_milli(r_idx)) * TPROD_W'(i_room_size);
                TS_DIV: r_m <= M_W'(r_p[TPROD_W-1:16]) * M_W'(RECIP_1000);
                TS_STORE: begin
                    if (r_idx < TAP_IW'(N_COMB)) begin
                        r_taps.comb_d[r_idx[K_W-1:0]] <= (d_raw > D_W'(COMB_DEPTH - 1))
                            ? COMB_AW'(COMB_DEPTH - 1) : d_raw[COMB_AW-1:0];
                    end else begin
                        r_taps.ap_d[2'(r_idx - TAP_IW'(N_COMB))] <=
                            (d_raw > D_W'(AP_DEPTH - 1))
                            ? AP_AW'(AP_DEPTH - 1) : d_raw[AP_AW-1:0];
                    end
                    r_idx <= r_idx + TAP_IW'(1);
                    if (last_tap) begin
                        r_taps.valid <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_taps = r_taps;

endmodule

/* rtl/srv_fifo.sv */
// Two-entry queue between the accepting front and the filter engine.
`timescale 1ns / 1ps
module srv_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  srv_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output srv_pkg::t_item o_item
);
    import srv_pkg::*;

    t_item      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];

endmodule

/* rtl/srv_core.sv */
// Filter engine: comb and allpass delay lines, mix and result register.
`timescale 1ns / 1ps
module srv_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  srv_pkg::t_taps            i_taps,
    input  logic [srv_pkg::CFG_W-1:0] i_dry_wet,
    input  logic                      i_fifo_valid,
    input  srv_pkg::t_item            i_item,
    output logic                      o_pop,
    srv_out_if.source                 o_out_ch
);
    import srv_pkg::*;

    t_core_state r_state, n_state;

    logic [SAMPLE_BITS*COMB_LANES-1:0] comb_mem [COMB_DEPTH];
    logic [SAMPLE_BITS*AP_LANES-1:0]   ap_mem   [AP_DEPTH];
    logic [SAMPLE_BITS*COMB_LANES-1:0] r_crow;
    logic [SAMPLE_BITS*AP_LANES-1:0]   r_arow;

    logic [COMB_AW-1:0] r_clr;
    logic [COMB_AW-1:0] r_cpos;
    logic [AP_AW-1:0]   r_apos;
    logic               r_ch;
    logic [K_W-1:0]     r_k;
    t_item              r_item;
    t_sample            r_x, r_v, r_y, r_wet_l, r_wet_r, r_res_l, r_res_r;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [MIX_W-1:0]  r_pw, r_pd;
    logic               r_ovalid;
    t_sample            r_out_l, r_out_r;
    logic               r_out_last;

    logic               clr_done, load_out, comb_wr, ap_wr;
    logic [LANE_W-1:0]  clane;
    logic [LANE_W-1:0]  alane;
    logic [COMB_AW:0]   cd, cpos_w;
    logic [AP_AW:0]     ad, apos_w;
    logic [COMB_AW-1:0] craddr;
    logic [AP_AW-1:0]   araddr;
    t_sample            cy, ab, c_o, a_w, wet, dry, mix_o;
    logic signed [SUM_W-1:0] sum_r;
    logic [CFG_W-1:0]   dwc;
    logic signed [DW_W-1:0] dws, dds;
    logic signed [WIDE-1:0] mix_t;

    assign clr_done = (r_clr == COMB_AW'(COMB_DEPTH - 1));
    assign load_out = (r_state == CS_DONE) && (!r_ovalid || o_out_ch.ready);

    // Lane numbers and read addresses, pos - d modulo the line depth
    assign clane  = {r_ch, r_k};
    assign alane  = LANE_W'(r_k) + (r_ch ? LANE_W'(N_AP) : LANE_W'(0));
    assign cd     = (COMB_AW+1)'(i_taps.comb_d[r_k]);
    assign cpos_w = (COMB_AW+1)'(r_cpos);
    assign craddr = (cpos_w >= cd) ? COMB_AW'(cpos_w - cd)
                                   : COMB_AW'(cpos_w + (COMB_AW+1)'(COMB_DEPTH) - cd);
    assign ad     = (AP_AW+1)'(i_taps.ap_d[r_k[1:0]]);
    assign apos_w = (AP_AW+1)'(r_apos);
    assign araddr = (apos_w >= ad) ? AP_AW'(apos_w - ad)
                                   : AP_AW'(apos_w + (AP_AW+1)'(AP_DEPTH) - ad);

    // Filter arithmetic
    assign cy    = r_crow[clane*SAMPLE_BITS +: SAMPLE_BITS];
    assign ab    = r_arow[alane*SAMPLE_BITS +: SAMPLE_BITS];
    assign c_o   = sat_s(WIDE'(r_x) + WIDE'(rnd_q15(r_prod)));
    assign a_w   = sat_s(WIDE'(r_v) + WIDE'(rnd_q15(r_prod)));
    assign sum_r = (r_sum + SUM_W'(2)) >>> 2;
    assign comb_wr = (r_state == CS_CWR);
    assign ap_wr   = (r_state == CS_AWR);

    // Dry/wet mix
    assign dwc   = (i_dry_wet > CFG_W'(Q16_ONE)) ? CFG_W'(Q16_ONE) : i_dry_wet;
    assign dws   = signed'({1'b0, dwc});
    assign dds   = signed'(DW_W'(Q16_ONE) - {1'b0, dwc});
    assign wet   = r_ch ? r_wet_r : r_wet_l;
    assign dry   = r_ch ? r_item.right : r_item.left;
    assign mix_t = (WIDE'(r_pw) + WIDE'(r_pd) + WIDE'(32768)) >>> 16;
    assign mix_o = sat_s(mix_t);

    // Delay memories: clearing pass after reset, lane writes, registered reads
    always_ff @(posedge i_clk) begin
        if (r_state == CS_CLEAR) begin
            comb_mem[r_clr] <= '0;
            if (r_clr < COMB_AW'(AP_DEPTH)) begin
                ap_mem[r_clr[AP_AW-1:0]] <= '0;
            end
        end else begin
            if (comb_wr) comb_mem[r_cpos][clane*SAMPLE_BITS +: SAMPLE_BITS] <= c_o;
            if (ap_wr)   ap_mem[r_apos][alane*SAMPLE_BITS +: SAMPLE_BITS]   <= a_w;
        end
        r_crow <= comb_mem[craddr];
        r_arow <= ap_mem[araddr];
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and queue pop
    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        unique case (r_state)
            CS_CLEAR: if (clr_done) n_state = CS_IDLE;
            CS_IDLE: begin
                if (i_fifo_valid && i_taps.valid) begin
                    o_pop   = 1'b1;
                    n_state = CS_CRD;
                end
            end
            CS_CRD:  n_state = CS_CMUL;
            CS_CMUL: n_state = CS_CWR;
            CS_CWR:  n_state = (r_k == K_W'(N_COMB - 1)) ? CS_CSUM : CS_CRD;
            CS_CSUM: n_state = CS_ARD;
            CS_ARD:  n_state = CS_AY;
            CS_AY:   n_state = CS_AMUL;
            CS_AMUL: n_state = CS_AWR;
            CS_AWR: begin
                if (r_k != K_W'(N_AP - 1)) begin
                    n_state = CS_ARD;
                end else begin
                    n_state = r_ch ? CS_MXM : CS_CRD;
                end
            end
            CS_MXM:  n_state = CS_MXA;
            CS_MXA:  n_state = r_ch ? CS_DONE : CS_MXM;
            CS_DONE: if (load_out) n_state = CS_IDLE;
            default: n_state = CS_IDLE;
        endcase
    end

    // Control counters and write positions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_cpos <= '0;
            r_apos <= '0;
            r_ch   <= 1'b0;
            r_k    <= '0;
        end else begin
            if (r_state == CS_CLEAR) r_clr <= r_clr + COMB_AW'(1);
            unique case (r_state)
                CS_IDLE: begin
                    r_ch <= 1'b0;
                    r_k  <= '0;
                end
                CS_CWR, CS_CSUM: r_k <= (r_state == CS_CSUM) ? '0 : r_k + K_W'(1);
                CS_AWR: begin
                    if (r_k == K_W'(N_AP - 1)) begin
                        r_k  <= '0;
                        r_ch <= ~r_ch;
                    end else begin
                        r_k <= r_k + K_W'(1);
                    end
                end
                CS_MXA: r_ch <= ~r_ch;
                CS_DONE: begin
                    if (load_out) begin
                        r_cpos <= (r_cpos == COMB_AW'(COMB_DEPTH - 1))
                                  ? '0 : r_cpos + COMB_AW'(1);
                        r_apos <= (r_apos == AP_AW'(AP_DEPTH - 1))
                                  ? '0 : r_apos + AP_AW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // Sample datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            CS_IDLE: begin
                r_item <= i_item;
                r_x    <= i_item.left;
                r_sum  <= '0;
            end
            CS_CMUL: r_prod <= comb_gain(r_k) * cy;
            CS_CWR:  r_sum  <= r_sum + SUM_W'(c_o);
            CS_CSUM: r_v    <= sum_r[SAMPLE_BITS-1:0];
            CS_ARD:  r_prod <= AP_GAIN * r_v;
            CS_AY:   r_y    <= sat_s(WIDE'(ab) - WIDE'(rnd_q15(r_prod)));
            CS_AMUL: r_prod <= AP_GAIN * r_y;
            CS_AWR: begin
                r_v <= r_y;
                if (r_k == K_W'(N_AP - 1)) begin
                    if (r_ch) begin
                        r_wet_r <= r_y;
                    end else begin
                        r_wet_l <= r_y;
                        r_x     <= r_item.right;
                        r_sum   <= '0;
                    end
                end
            end
            CS_MXM: begin
                r_pw <= wet * dws;
                r_pd <= dry * dds;
            end
            CS_MXA: begin
                if (r_ch) r_res_r <= mix_o;
                else      r_res_l <= mix_o;
            end
            default: ;
        endcase
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (load_out) begin
            r_ovalid <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_l    <= r_res_l;
            r_out_r    <= r_res_r;
            r_out_last <= r_item.last;
        end
    end

    assign o_out_ch.valid     = r_ovalid;
    assign o_out_ch.left_out  = r_out_l;
    assign o_out_ch.right_out = r_out_r;
    assign o_out_ch.last_out  = r_out_last;

    // Checks
    a_pop_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == CS_IDLE) && i_taps.valid)
        else $error("queue popped while engine not ready");
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == CS_DONE))
        else $error("result raised outside the done state");
    a_ap_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == CS_ARD) |-> (r_k <= K_W'(N_AP - 1)))
        else $error("allpass index out of range");
    a_pos_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != CS_DONE) |=> $stable(r_cpos) && $stable(r_apos))
        else $error("write position moved mid item");

endmodule

/* tb/tb_stereo_schroeder_reverb_top.sv */
// Testbench for the stereo Schroeder reverb: random stimulus checked against a behavioral predictor.
`timescale 1ns / 1ps
module tb_stereo_schroeder_reverb_top;
    import srv_pkg::*;

    // Expected-output tracker with its own copy of the reverb state
    class reverb_scoreboard;
        int unsigned room;
        int unsigned wet_share;
        int signed comb_mem [0:2*N_COMB*COMB_DEPTH-1];
        int signed ap_mem [0:2*N_AP*AP_DEPTH-1];
        int unsigned comb_pos;
        int unsigned ap_pos;
        t_item expected_q[$];
        int unsigned mismatches;
        int unsigned results_seen;

        function void clear_state();
            foreach (comb_mem[i]) comb_mem[i] = 0;
            foreach (ap_mem[i]) ap_mem[i] = 0;
            comb_pos = 0;
            ap_pos = 0;
            room = 0;
            wet_share = 0;
            mismatches = 0;
            results_seen = 0;
        endfunction

        function longint clip(longint v);
            longint hi;
            hi = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
            if (v > hi) return hi;
            if (v < -hi - 1) return -hi - 1;
            return v;
        endfunction

        function longint scale_q15(longint g, longint x);
            return (g * x + 16384) >>> 15;
        endfunction

        function int unsigned delay_of(longint unsigned base, int unsigned depth);
            longint unsigned d;
            d = (base * room) / 64'd65536000;
            if (d > depth - 1) d = depth - 1;
            return int'(d);
        endfunction

        function longint filter_channel(int ch, longint x);
            longint unsigned comb_base[4] = '{16930872, 17636472, 19047672, 20465928};
            longint unsigned ap_base[3] = '{3707928, 1188936, 398664};
            longint comb_g[4] = '{24315, 24019, 23429, 22839};
            longint sum, v, y, b, o;
            int unsigned d, rp, line;
            sum = 0;
            for (int k = 0; k < N_COMB; k++) begin
                line = (ch * N_COMB + k) * COMB_DEPTH;
                d = delay_of(comb_base[k], COMB_DEPTH);
                rp = (comb_pos >= d) ? comb_pos - d : comb_pos + COMB_DEPTH - d;
                y = comb_mem[line + rp];
                o = clip(x + scale_q15(comb_g[k], y));
                comb_mem[line + comb_pos] = int'(o);
                sum += o;
            end
            v = (sum + 2) >>> 2;
            for (int k = 0; k < N_AP; k++) begin
                line = (ch * N_AP + k) * AP_DEPTH;
                d = delay_of(ap_base[k], AP_DEPTH);
                rp = (ap_pos >= d) ? ap_pos - d : ap_pos + AP_DEPTH - d;
                b = ap_mem[line + rp];
                y = clip(b - scale_q15(22938, v));
                ap_mem[line + ap_pos] = int'(clip(v + scale_q15(22938, y)));
                v = y;
            end
            return v;
        endfunction

        function longint blend(longint wet, longint dry);
            longint dw;
            dw = (wet_share > Q16_ONE) ? Q16_ONE : wet_share;
            return clip((wet * dw + dry * (Q16_ONE - dw) + 32768) >>> 16);
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_W-1:0] val);
            if (idx == REG_ROOM_SIZE) room = val;
            else if (idx == REG_DRY_WET) wet_share = val;
        endfunction

        // Accepted input: advance the model and queue the expected pair
        function void note_input(t_item it);
            longint l, r, wl, wr;
            t_item e;
            l = it.left;
            r = it.right;
            wl = filter_channel(0, l);
            wr = filter_channel(1, r);
            comb_pos = (comb_pos + 1 >= COMB_DEPTH) ? 0 : comb_pos + 1;
            ap_pos = (ap_pos + 1 >= AP_DEPTH) ? 0 : ap_pos + 1;
            e.left = t_sample'(blend(wl, l));
            e.right = t_sample'(blend(wr, r));
            e.last = it.last;
            expected_q.push_back(e);
        endfunction

        function void check_result(t_item got);
            t_item e;
            results_seen++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result L=%0d R=%0d", got.left, got.right);
                return;
            end
            e = expected_q.pop_front();
            if (got !== e) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch #%0d: exp L=%0d R=%0d last=%b, got L=%0d R=%0d last=%b",
                             results_seen, e.left, e.right, e.last,
                             got.left, got.right, got.last);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    srv_in_if in_ch();
    srv_out_if out_ch();
    srv_cfg_if cfg_ch();

    stereo_schroeder_reverb_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_ch(in_ch.sink), .o_out_ch(out_ch.source), .i_cfg(cfg_ch.sink)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    reverb_scoreboard sb;
    bit hold_off = 1'b0;
    bit stall_enable = 1'b0;
    longint unsigned cycles = 0;
    localparam longint unsigned CYCLE_LIMIT = 2_000_000;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.left_in = '0;
        in_ch.right_in = '0;
        in_ch.last_sample = 1'b0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
    end

    // Monitor accepted input and result transactions
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready)
                sb.note_input('{in_ch.left_in, in_ch.right_in, in_ch.last_sample});
            if (out_ch.valid && out_ch.ready)
                sb.check_result('{out_ch.left_out, out_ch.right_out, out_ch.last_out});
        end
    end

    // Receiver backpressure: own stall pattern, plus the long hold-off
    always @(posedge i_clk) begin
        if (hold_off || !i_rst_n)
            out_ch.ready <= 1'b0;
        else if (stall_enable)
            out_ch.ready <= ($urandom_range(0, 9) > 3);
        else
            out_ch.ready <= 1'b1;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
    end

    // One register write transaction; valid is then dropped and the channel left idle
    task automatic write_cfg(t_cfg_idx idx, logic [CFG_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.write_reg(idx, val);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Send one sample pair; valid stays high when another follows directly
    task automatic send_pair(t_sample l, t_sample r, logic last, bit keep_valid);
        in_ch.valid <= 1'b1;
        in_ch.left_in <= l;
        in_ch.right_in <= r;
        in_ch.last_sample <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        if (!keep_valid) in_ch.valid <= 1'b0;
    endtask

    function automatic t_sample rand_sample();
        case ($urandom_range(0, 5))
            0: return t_sample'(24'h7FFFFF);
            1: return t_sample'(24'h800000);
            2: return t_sample'($urandom_range(0, 255) - 128);
            default: return t_sample'($urandom);
        endcase
    endfunction

    // Burst of pairs; a dropped valid is always followed by an idle gap
    task automatic send_burst(int n);
        int gap;
        bit keep;
        for (int i = 0; i < n; i++) begin
            keep = (i != n - 1) && ($urandom_range(0, 2) != 0);
            send_pair(rand_sample(), rand_sample(), $urandom_range(0, 7) == 0, keep);
            if (!keep) begin
                gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 80) : 1;
                repeat (gap) @(posedge i_clk);
            end
        end
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drain();
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    int sent;
    initial begin
        logic [CFG_W-1:0] rooms[5] = '{0, 65536, 120000, 1000, 32768};
        logic [CFG_W-1:0] mixes[5] = '{0, 65536, 131071, 32768, 50000};
        int nb;
        sb = new();
        sb.clear_state();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, zero delay at reset settings, last mark
        send_pair(t_sample'(24'h7FFFFF), t_sample'(24'h800000), 1'b0, 1'b1);
        send_pair(t_sample'(24'h800000), t_sample'(24'h7FFFFF), 1'b1, 1'b1);
        send_pair('0, '0, 1'b0, 1'b1);
        send_pair(t_sample'(-1), t_sample'(1), 1'b1, 1'b0);
        wait_drain();
        write_cfg(REG_ROOM_SIZE, 17'd65536);
        write_cfg(REG_DRY_WET, 17'd131071);
        write_cfg(t_cfg_idx'(2), 17'd12345);
        write_cfg(t_cfg_idx'(1), 17'd65536);
        for (int i = 0; i < 12; i++)
            send_pair(t_sample'(i[0] ? 24'h7FFFFF : 24'h800000),
                      t_sample'(i[1] ? 24'h7FFFFF : 24'h800000), i[2], 1'b1);
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        wait_drain();

        // Long receiver hold-off while the sender keeps offering
        stall_enable = 1'b1;
        hold_off = 1'b1;
        fork
            send_burst(10);
            begin
                repeat (2000) @(posedge i_clk);
                hold_off = 1'b0;
            end
        join
        wait_drain();

        // Random phases across register settings
        sent = 26;
        for (int ph = 0; ph < 10; ph++) begin
            write_cfg(REG_ROOM_SIZE, ph < 5 ? rooms[ph] : 17'($urandom_range(0, 131071)));
            write_cfg(REG_DRY_WET, ph < 5 ? mixes[ph] : 17'($urandom_range(0, 70000)));
            stall_enable = ph[0];
            for (int b = 0; b < 12; b++) begin
                nb = $urandom_range(1, 19);
                send_burst(nb);
                sent += nb;
            end
            wait_drain();
        end

        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("Sent %0d pairs, checked %0d results over ten register settings,",
                 sent, sb.results_seen);
        $display("incl. extremes, an unknown register index and backpressure.");
        $display("Mismatches: %0d", sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
